### rtl/lrtoa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrtoa_pkg
// Shared types and constants for the LoRa time-on-air core: field widths,
// configuration register indexes, the queue item and the status bundle.
// ----------------------------------------------------------------------------
package lrtoa_pkg;

    // field and datapath widths
    localparam int PL_W          = 8;    // payload length in bytes
    localparam int SYM_W         = 12;   // payload symbol count field
    localparam int TOA_W         = 36;   // time on air field, microseconds
    localparam int SF_W          = 4;
    localparam int BW_W          = 19;
    localparam int CR_W          = 3;
    localparam int PRE_W         = 16;
    localparam int NSYM_W        = 13;   // exact symbol count, up to 5739
    localparam int PROD_W        = 14;   // quotient times coding factor
    localparam int SDIV_W        = 10;   // symbol divider dividend / quotient
    localparam int SDVS_W        = 4;    // symbol divider divisor
    localparam int SYM_DIV_STEPS = SDIV_W;
    localparam int QTR_W         = 19;   // packet length in quarter symbols
    localparam int US_W          = 20;
    localparam int MUL_W         = QTR_W + US_W;
    localparam int NUM_W         = 55;   // airtime dividend incl. rounding term
    localparam int DEN_W         = BW_W + 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = BW_W;

    // constants
    localparam logic [US_W-1:0]   US_PER_S        = 20'd1000000;
    localparam logic [PL_W-1:0]   MAX_PAYLOAD_LEN = 8'd255;
    localparam logic [SYM_W-1:0]  SYM_FIELD_MAX   = 12'hFFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPREADING_FACTOR  = 3'd0,
        CFG_BANDWIDTH_HZ      = 3'd1,
        CFG_CODING_RATE       = 3'd2,
        CFG_LOW_RATE_OPTIMIZE = 3'd3,
        CFG_IMPLICIT_HEADER   = 3'd4,
        CFG_CRC_PRESENT       = 3'd5,
        CFG_PREAMBLE_SYMBOLS  = 3'd6
    } cfg_index_t;

    // current configuration
    typedef struct packed {
        logic [SF_W-1:0]  spreading_factor;
        logic [BW_W-1:0]  bandwidth_hz;
        logic [CR_W-1:0]  coding_rate;
        logic             low_rate_optimize;
        logic             implicit_header;
        logic             crc_present;
        logic [PRE_W-1:0] preamble_symbols;
    } cfg_t;

    // item handed from the symbol front end to the airtime back end
    typedef struct packed {
        logic [QTR_W-1:0] quarters;
        logic [SYM_W-1:0] sym;
    } item_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage : lrtoa_pkg
`default_nettype wire

### rtl/lora_time_on_air_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lora_time_on_air_core
// LoRa packet time on air: payload symbol count and airtime in microseconds
// for each payload length, from the programmed radio settings.
// ----------------------------------------------------------------------------
// datapath order: front end with 10-step symbol divider, queue, back end with
//   36-step airtime divider
// throughput: one item per cycle while the output accepts; every divider step has its own stage
// reset: configuration returns to sf 7, 125 kHz, 4/5, crc on, preamble 8;
//   all pipelines and the queue come up empty
// ----------------------------------------------------------------------------
module lora_time_on_air_core
    import lrtoa_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] payload_length
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [11:0] payload_symbols, [47:12] time_on_air_us
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    logic              push;
    logic              pop;
    item_t             front_item;
    item_t             queue_item;
    q_status_t         q_stat;
    logic [SYM_W-1:0]  out_sym;
    logic [TOA_W-1:0]  out_time;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {out_time, out_sym};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spreading_factor  <= 4'd7;
            cfg_reg.bandwidth_hz      <= 19'd125000;
            cfg_reg.coding_rate       <= 3'd1;
            cfg_reg.low_rate_optimize <= 1'b0;
            cfg_reg.implicit_header   <= 1'b0;
            cfg_reg.crc_present       <= 1'b1;
            cfg_reg.preamble_symbols  <= 16'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SPREADING_FACTOR:  cfg_reg.spreading_factor  <= cfg_data[SF_W-1:0];
                CFG_BANDWIDTH_HZ:      cfg_reg.bandwidth_hz      <= cfg_data[BW_W-1:0];
                CFG_CODING_RATE:       cfg_reg.coding_rate       <= cfg_data[CR_W-1:0];
                CFG_LOW_RATE_OPTIMIZE: cfg_reg.low_rate_optimize <= cfg_data[0];
                CFG_IMPLICIT_HEADER:   cfg_reg.implicit_header   <= cfg_data[0];
                CFG_CRC_PRESENT:       cfg_reg.crc_present       <= cfg_data[0];
                CFG_PREAMBLE_SYMBOLS:  cfg_reg.preamble_symbols  <= cfg_data[PRE_W-1:0];
                default:               cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // symbol count front end
    lrtoa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_length (s_tdata),
        .out_valid (push),
        .out_ready (!q_stat.full),
        .out_item  (front_item)
    );

    // decoupling queue
    lrtoa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push && !q_stat.full),
        .wr_item (front_item),
        .pop     (pop),
        .rd_item (queue_item),
        .status  (q_stat)
    );

    // airtime back end
    lrtoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (!q_stat.empty),
        .in_take   (pop),
        .in_item   (queue_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_sym   (out_sym),
        .out_time  (out_time)
    );

    // every packet carries at least the eight fixed payload symbols
    a_sym_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:0] >= 12'd8))
        else $error("payload symbol count below eight");

    // airtime of a packet is never zero
    a_time_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[47:12] != 36'd0))
        else $error("zero time on air");

    // input backpressure only comes from a full queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_stat.full)
        else $error("input stalled while queue has room");

endmodule : lora_time_on_air_core
`default_nettype wire

### rtl/lrtoa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrtoa_front
// Front end: takes payload lengths, computes the payload symbol count with a
// pipelined ceiling divider and forms the packet length in quarter symbols.
// ----------------------------------------------------------------------------
module lrtoa_front
    import lrtoa_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [PL_W-1:0] in_length,
    output logic            out_valid,
    input  logic            out_ready,
    output item_t           out_item
);

    // entry stage, divider steps, symbol count stage, output stage
    localparam int STAGES = SYM_DIV_STEPS + 3;
    localparam int LAST   = STAGES - 1;

    logic [STAGES-1:0]  vld_reg;
    logic               en;

    logic [PL_W-1:0]    pl_sat;
    logic [11:0]        pos_part;
    logic [6:0]         neg_part;
    logic [11:0]        diff;
    logic [11:0]        diff_rnd;
    logic [SDIV_W-1:0]  n4;
    logic [SDVS_W-1:0]  de2;
    logic [SDVS_W-1:0]  divisor;
    logic [SDIV_W-1:0]  a_next;
    logic [SDIV_W-1:0]  a_reg;

    logic [SDVS_W-1:0]  rem_in   [SYM_DIV_STEPS];
    logic [SDIV_W-1:0]  aq_in    [SYM_DIV_STEPS];
    logic [SDVS_W:0]    trial    [SYM_DIV_STEPS];
    logic [SDVS_W:0]    trial_d  [SYM_DIV_STEPS];
    logic               ge       [SYM_DIV_STEPS];
    logic [SDVS_W-1:0]  rem_next [SYM_DIV_STEPS];
    logic [SDIV_W-1:0]  aq_next  [SYM_DIV_STEPS];
    logic [SDVS_W-1:0]  rem_reg  [SYM_DIV_STEPS];
    logic [SDIV_W-1:0]  aq_reg   [SYM_DIV_STEPS];

    logic [3:0]         cr_factor;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  prod_ofs;
    logic [NSYM_W-1:0]  nsym_next;
    logic [NSYM_W-1:0]  nsym_reg;
    item_t              item_next;
    item_t              item_reg;

    // whole pipeline moves together when the last stage can drain
    assign en        = !vld_reg[LAST] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[LAST];
    assign out_item  = item_reg;

    // entry: saturate length, numerator, ceiling by four, divisor
    always_comb
    begin
        pl_sat   = (in_length > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : in_length;
        pos_part = {1'b0, pl_sat, 3'b000} + 12'd28 + {7'b0, cfg.crc_present, 4'b0000};
        neg_part = {1'b0, cfg.spreading_factor, 2'b00}
                   + (cfg.implicit_header ? 7'd20 : 7'd0);
        diff     = pos_part - {5'b0, neg_part};
        diff_rnd = diff + 12'd3;
        n4       = (pos_part > {5'b0, neg_part}) ? diff_rnd[11:2] : '0;
        de2      = {2'b00, cfg.low_rate_optimize, 1'b0};
        divisor  = (cfg.spreading_factor > de2) ? cfg.spreading_factor - de2 : 4'd1;
        // ceiling division as floor of (n + d - 1) / d
        a_next   = n4 + {{(SDIV_W-SDVS_W){1'b0}}, divisor} - {{(SDIV_W-1){1'b0}}, 1'b1};
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin
        rem_in[0] = '0;
        aq_in[0]  = a_reg;
        for (int k = 1; k < SYM_DIV_STEPS; k++)
        begin
            rem_in[k] = rem_reg[k-1];
            aq_in[k]  = aq_reg[k-1];
        end
        for (int k = 0; k < SYM_DIV_STEPS; k++)
        begin
            trial[k]    = {rem_in[k], aq_in[k][SDIV_W-1]};
            trial_d[k]  = trial[k] - {1'b0, divisor};
            ge[k]       = trial[k] >= {1'b0, divisor};
            rem_next[k] = ge[k] ? trial_d[k][SDVS_W-1:0] : trial[k][SDVS_W-1:0];
            aq_next[k]  = {aq_in[k][SDIV_W-2:0], ge[k]};
        end
    end

    // symbol count and quarter-symbol packet length
    always_comb
    begin
        cr_factor = {1'b0, cfg.coding_rate} + 4'd4;
        prod      = {{(PROD_W-SDIV_W){1'b0}}, aq_reg[SYM_DIV_STEPS-1]}
                    * {{(PROD_W-4){1'b0}}, cr_factor};
        prod_ofs  = prod + 14'd8;
        nsym_next = prod_ofs[NSYM_W-1:0];
        item_next.sym      = (nsym_reg > {1'b0, SYM_FIELD_MAX}) ? SYM_FIELD_MAX
                                                                 : nsym_reg[SYM_W-1:0];
        item_next.quarters = {1'b0, cfg.preamble_symbols, 2'b00} + 19'd17
                             + {4'b0, nsym_reg, 2'b00};
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            for (int k = 0; k < SYM_DIV_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                aq_reg[k]  <= aq_next[k];
            end
            nsym_reg <= nsym_next;
            item_reg <= item_next;
        end
    end

endmodule : lrtoa_front
`default_nettype wire

### rtl/lrtoa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrtoa_queue
// Short first-in first-out queue between the front end and the back end,
// so that either side can stall on its own.
// ----------------------------------------------------------------------------
module lrtoa_queue
    import lrtoa_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  item_t     wr_item,
    input  logic      pop,
    output item_t     rd_item,
    output q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign rd_item      = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule : lrtoa_queue
`default_nettype wire

### rtl/lrtoa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrtoa_back
// Back end: scales the quarter-symbol count to chips and microseconds and
// divides by four times the bandwidth with a pipelined restoring divider,
// rounding to nearest and saturating to the field width.
// ----------------------------------------------------------------------------
module lrtoa_back
    import lrtoa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_take,
    input  item_t            in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SYM_W-1:0] out_sym,
    output logic [TOA_W-1:0] out_time
);

    // multiply, shift, divider setup, divider steps, output register
    localparam int TOA_STEPS = TOA_W;
    localparam int STAGES    = 2 + (TOA_STEPS + 1) + 1;
    localparam int LAST      = STAGES - 1;
    localparam int HI_W      = NUM_W - TOA_W;

    logic [STAGES-1:0]  vld_reg;
    logic               en;

    logic [MUL_W-1:0]   prod_next;
    logic [MUL_W-1:0]   prod_reg;
    logic [NUM_W-1:0]   n_next;
    logic [NUM_W-1:0]   n_reg;
    logic [DEN_W-1:0]   dvs;
    logic [HI_W-1:0]    hi;

    logic [DEN_W:0]     trial    [TOA_STEPS+1];
    logic [DEN_W:0]     trial_d  [TOA_STEPS+1];
    logic               ge       [TOA_STEPS+1];
    logic [DEN_W-1:0]   rem_next [TOA_STEPS+1];
    logic [TOA_W-1:0]   wq_next  [TOA_STEPS+1];
    logic               ovf_next [TOA_STEPS+1];
    logic [DEN_W-1:0]   rem_reg  [TOA_STEPS+1];
    logic [TOA_W-1:0]   wq_reg   [TOA_STEPS+1];
    logic               ovf_reg  [TOA_STEPS+1];

    logic [SYM_W-1:0]   sym_reg  [STAGES];
    logic [TOA_W-1:0]   time_next;
    logic [TOA_W-1:0]   time_reg;

    // pipeline advances when the output register is free or taken
    assign en        = !vld_reg[LAST] || out_ready;
    assign in_take   = en && in_valid;
    assign out_valid = vld_reg[LAST];
    assign out_sym   = sym_reg[LAST];
    assign out_time  = time_reg;

    // scaling: quarters times one million, then times two to the sf
    always_comb
    begin
        prod_next = MUL_W'(in_item.quarters) * MUL_W'(US_PER_S);
        n_next    = (NUM_W'(prod_reg) << cfg.spreading_factor)
                    + NUM_W'({cfg.bandwidth_hz, 1'b0});
    end

    // divider setup and steps; an upper part not below the divisor saturates
    always_comb
    begin
        dvs         = {cfg.bandwidth_hz, 2'b00};
        hi          = n_reg[NUM_W-1:TOA_W];
        trial[0]    = '0;
        trial_d[0]  = '0;
        ge[0]       = 1'b0;
        rem_next[0] = DEN_W'(hi);
        wq_next[0]  = n_reg[TOA_W-1:0];
        ovf_next[0] = (DEN_W'(hi) >= dvs);
        for (int k = 1; k <= TOA_STEPS; k++)
        begin
            trial[k]    = {rem_reg[k-1], wq_reg[k-1][TOA_W-1]};
            trial_d[k]  = trial[k] - {1'b0, dvs};
            ge[k]       = trial[k] >= {1'b0, dvs};
            rem_next[k] = ge[k] ? trial_d[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
            wq_next[k]  = {wq_reg[k-1][TOA_W-2:0], ge[k]};
            ovf_next[k] = ovf_reg[k-1];
        end
        time_next = ovf_reg[TOA_STEPS] ? '1 : wq_reg[TOA_STEPS];
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            n_reg    <= n_next;
            for (int k = 0; k <= TOA_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                wq_reg[k]  <= wq_next[k];
                ovf_reg[k] <= ovf_next[k];
            end
            sym_reg[0] <= in_item.sym;
            for (int p = 1; p < STAGES; p++)
            begin
                sym_reg[p] <= sym_reg[p-1];
            end
            time_reg <= time_next;
        end
    end

endmodule : lrtoa_back
`default_nettype wire

### tb/tb_lora_time_on_air_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lora_time_on_air_core
// Self-checking bench for the LoRa time-on-air core. Payload lengths are
// streamed under many radio settings. Each accepted length is turned into
// a predicted symbol count and airtime, and every output transaction is
// compared in order. Both stream sides idle at random, and the output side
// also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_lora_time_on_air_core;
    import lrtoa_pkg::*;

    localparam int STALL_LIMIT  = 5000;   // cycles with no transaction at all
    localparam int DRAIN_CYCLES = 64;     // wait after the last phase before the verdict
    localparam int HOLD_CYCLES  = 300;    // long output hold-off
    localparam int RANDOM_ITEMS = 430;
    localparam int CALM_TAIL    = 80;     // last items run without idling
    localparam logic [TOA_W-1:0] TOA_FIELD_MAX = '1;

    // predicts airtime per payload length and checks the output stream
    class airtime_scoreboard;
        typedef struct packed {
            logic [PL_W-1:0]  payload_length;
            logic [SYM_W-1:0] payload_symbols;
            logic [TOA_W-1:0] time_on_air_us;
        } airtime_t;

        cfg_t        radio;
        airtime_t    airtime_q[$];
        int unsigned failures;

        function new();
            radio.spreading_factor  = 4'd7;
            radio.bandwidth_hz      = 19'd125000;
            radio.coding_rate       = 3'd1;
            radio.low_rate_optimize = 1'b0;
            radio.implicit_header   = 1'b0;
            radio.crc_present       = 1'b1;
            radio.preamble_symbols  = 16'd8;
            failures = 0;
        endfunction

        function int pending();
            return airtime_q.size();
        endfunction

        // register write transaction, kept to each register's width
        function void write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SPREADING_FACTOR:  radio.spreading_factor  = data[SF_W-1:0];
                CFG_BANDWIDTH_HZ:      radio.bandwidth_hz      = data[BW_W-1:0];
                CFG_CODING_RATE:       radio.coding_rate       = data[CR_W-1:0];
                CFG_LOW_RATE_OPTIMIZE: radio.low_rate_optimize = data[0];
                CFG_IMPLICIT_HEADER:   radio.implicit_header   = data[0];
                CFG_CRC_PRESENT:       radio.crc_present       = data[0];
                CFG_PREAMBLE_SYMBOLS:  radio.preamble_symbols  = data[PRE_W-1:0];
                default: ;
            endcase
        endfunction

        // symbol count and airtime for one accepted payload length
        function void note_payload(logic [PL_W-1:0] len);
            int sf_i, pl_i, cr_i, de_i, ih_i, crc_i;
            int num, span, den, quot, prod;
            longint unsigned nsym, pre, bw, quarters, numer, denom, usec;
            airtime_t e;
            sf_i  = int'(radio.spreading_factor);
            pl_i  = int'(len);
            cr_i  = int'(radio.coding_rate);
            de_i  = int'(radio.low_rate_optimize);
            ih_i  = int'(radio.implicit_header);
            crc_i = int'(radio.crc_present);
            pre   = 64'(radio.preamble_symbols);
            bw    = 64'(radio.bandwidth_hz);

            // signed ceiling of the payload bits over the symbol capacity
            num  = 8 * pl_i - 4 * sf_i + 28 + 16 * crc_i - 20 * ih_i;
            span = sf_i - 2 * de_i;
            if (span < 1)
                span = 1;
            den = 4 * span;
            if (num >= 0)
                quot = (num + den - 1) / den;
            else
                quot = -((-num) / den);
            prod = quot * (cr_i + 4);
            if (prod < 0)
                prod = 0;
            nsym = 64'(8 + prod);

            // quarter symbols to microseconds, halves rounded up
            quarters = 4 * pre + 17 + 4 * nsym;
            numer    = (quarters << sf_i) * 64'd1000000;
            denom    = 4 * bw;
            if (denom == 0)
                usec = 64'(TOA_FIELD_MAX);
            else
            begin
                usec = (numer + denom / 2) / denom;
                if (usec > 64'(TOA_FIELD_MAX))
                    usec = 64'(TOA_FIELD_MAX);
            end

            e.payload_length  = len;
            e.payload_symbols = (nsym > 64'(SYM_FIELD_MAX)) ? SYM_FIELD_MAX
                                                             : nsym[SYM_W-1:0];
            e.time_on_air_us  = usec[TOA_W-1:0];
            airtime_q.push_back(e);
        endfunction

        // compare one output transaction with the oldest prediction
        function void check_result(logic [SYM_W+TOA_W-1:0] word);
            logic [SYM_W-1:0] sym;
            logic [TOA_W-1:0] toa;
            airtime_t e;
            sym = word[SYM_W-1:0];
            toa = word[SYM_W +: TOA_W];
            if (airtime_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: payload_symbols %0d time_on_air_us %0d",
                             sym, toa);
                return;
            end
            e = airtime_q.pop_front();
            if (sym !== e.payload_symbols || toa !== e.time_on_air_us)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch pl %0d: symbols exp %0d got %0d, airtime exp %0d got %0d",
                             e.payload_length, e.payload_symbols, sym,
                             e.time_on_air_us, toa);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit                src_idle;
    bit                sink_idle;
    int                sink_hold;
    int                stall_cycles = 0;
    airtime_scoreboard sb;

    always #4 clk = ~clk;

    lora_time_on_air_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // transaction monitor: inputs are noted before outputs are checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index_t'(cfg_index), cfg_data);
            if (s_tvalid && s_tready)
                sb.note_payload(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side: ready with random idle bursts and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            else if (sink_idle && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // one input transaction, optionally after an idle burst
    task automatic send_payload(input logic [PL_W-1:0] len);
        if (src_idle && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= len;
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending and wait for every predicted result
    task automatic close_phase();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // register write, bits above the register width filled at random
    task automatic put_register(input cfg_index_t idx, input int unsigned value, input int w);
        logic [CFG_DATA_W-1:0] keep;
        keep = (CFG_DATA_W'(1) << w) - CFG_DATA_W'(1);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
        do @(posedge clk); while (!cfg_ready);
    endtask

    // write all registers, or a random subset
    task automatic apply_settings(input cfg_t s, input bit every);
        if (every || $urandom_range(0, 3) != 0)
            put_register(CFG_SPREADING_FACTOR, s.spreading_factor, SF_W);
        if (every || $urandom_range(0, 3) != 0)
            put_register(CFG_BANDWIDTH_HZ, s.bandwidth_hz, BW_W);
        if (every || $urandom_range(0, 3) != 0)
            put_register(CFG_CODING_RATE, s.coding_rate, CR_W);
        if (every || $urandom_range(0, 3) != 0)
            put_register(CFG_LOW_RATE_OPTIMIZE, s.low_rate_optimize, 1);
        if (every || $urandom_range(0, 3) != 0)
            put_register(CFG_IMPLICIT_HEADER, s.implicit_header, 1);
        if (every || $urandom_range(0, 3) != 0)
            put_register(CFG_CRC_PRESENT, s.crc_present, 1);
        if (every || $urandom_range(0, 3) != 0)
            put_register(CFG_PREAMBLE_SYMBOLS, s.preamble_symbols, PRE_W);
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t make_settings(int sf, int bw, int cr, bit de, bit ih, bit crc,
                                           int pre);
        cfg_t s;
        s.spreading_factor  = SF_W'(sf);
        s.bandwidth_hz      = BW_W'(bw);
        s.coding_rate       = CR_W'(cr);
        s.low_rate_optimize = de;
        s.implicit_header   = ih;
        s.crc_present       = crc;
        s.preamble_symbols  = PRE_W'(pre);
        return s;
    endfunction

    // mostly usable radio settings, sometimes anything the fields hold
    function automatic cfg_t random_settings();
        cfg_t s;
        if ($urandom_range(0, 3) == 0)
        begin
            s.spreading_factor = SF_W'($urandom_range(0, 15));
            s.bandwidth_hz     = BW_W'($urandom);
            s.coding_rate      = CR_W'($urandom_range(0, 7));
            s.preamble_symbols = PRE_W'($urandom);
        end
        else
        begin
            s.spreading_factor = SF_W'($urandom_range(6, 12));
            case ($urandom_range(0, 3))
                0:       s.bandwidth_hz = 19'd125000;
                1:       s.bandwidth_hz = 19'd250000;
                2:       s.bandwidth_hz = 19'd500000;
                default: s.bandwidth_hz = BW_W'($urandom_range(7800, 500000));
            endcase
            s.coding_rate      = CR_W'($urandom_range(1, 4));
            s.preamble_symbols = PRE_W'($urandom_range(6, 16));
        end
        s.low_rate_optimize = 1'($urandom);
        s.implicit_header   = 1'($urandom);
        s.crc_present       = 1'($urandom);
        return s;
    endfunction

    function automatic logic [PL_W-1:0] random_payload();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? MAX_PAYLOAD_LEN : '0;
        return PL_W'($urandom_range(0, 255));
    endfunction

    // stimulus
    initial
    begin
        int sent;
        int burst;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SPREADING_FACTOR;
        cfg_data  = '0;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = 0;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // settings after reset
        send_payload(8'd0);
        send_payload(8'd255);
        send_payload(8'd1);
        send_payload(8'h55);
        send_payload(8'hAA);
        close_phase();

        // slowest usable corner, implicit header, no crc, longest preamble
        apply_settings(make_settings(12, 7800, 4, 1'b1, 1'b1, 1'b0, 65535), 1'b1);
        send_payload(8'd0);
        send_payload(8'd255);
        close_phase();

        // fastest usable corner, empty preamble
        apply_settings(make_settings(6, 500000, 1, 1'b0, 1'b0, 1'b1, 0), 1'b1);
        send_payload(8'd0);
        send_payload(8'd255);
        close_phase();

        // zero bandwidth; sf 0 with rate index 7 overflows the symbol field
        apply_settings(make_settings(0, 0, 7, 1'b1, 1'b0, 1'b1, 0), 1'b1);
        send_payload(8'd255);
        send_payload(8'd0);
        close_phase();

        // airtime beyond the field; rate index 0
        apply_settings(make_settings(15, 1, 0, 1'b0, 1'b1, 1'b0, 65535), 1'b1);
        send_payload(8'd255);
        send_payload(8'd0);
        close_phase();

        // divisor reduced to one by low rate optimize; largest bandwidth code
        apply_settings(make_settings(3, 524287, 5, 1'b1, 1'b0, 1'b1, 12345), 1'b1);
        send_payload(8'd0);
        send_payload(8'd17);
        send_payload(8'd200);
        close_phase();

        // negative numerator, product clamped at zero; rate index 6
        apply_settings(make_settings(12, 125000, 6, 1'b1, 1'b1, 1'b0, 8), 1'b1);
        send_payload(8'd0);
        send_payload(8'd1);
        send_payload(8'd2);
        close_phase();

        // random phases, the first one against a long output hold-off
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            apply_settings(random_settings(), 1'b0);
            burst = $urandom_range(10, 40);
            if (RANDOM_ITEMS - sent <= CALM_TAIL)
            begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            else
            begin
                src_idle  = 1'($urandom);
                sink_idle = 1'($urandom);
            end
            if (sent == 0)
            begin
                burst     = 100;
                src_idle  = 1'b0;
                sink_hold = HOLD_CYCLES;
            end
            repeat (burst)
            begin
                send_payload(random_payload());
                sent++;
            end
            close_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
rtl/lrtoa_pkg.sv
rtl/lrtoa_front.sv
rtl/lrtoa_queue.sv
rtl/lrtoa_back.sv
rtl/lora_time_on_air_core.sv
tb/tb_lora_time_on_air_core.sv
